@@ sv/bsspd_pkg.sv @@
// Shared types, constants and the gain table of the block-scaled stereo PCM decoder.
package bsspd_pkg;

    localparam int unsigned GAIN_W     = 15;
    localparam int unsigned PROD_W     = 24;
    localparam int unsigned SHIFT      = 5;
    localparam int unsigned SCALED_W   = PROD_W - SHIFT;
    localparam int unsigned NIBBLE_W   = 4;

    localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

    localparam logic CHAN_LEFT  = 1'b0;
    localparam logic CHAN_RIGHT = 1'b1;

    typedef logic [GAIN_W-1:0] t_gain;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_start;
        logic       packet_end;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               channel;
        logic               sample_valid;
        logic               last_of_packet;
        logic               short_packet;
    } t_out_item;

    function automatic t_gain gain_lookup(input logic [NIBBLE_W-1:0] idx);
        t_gain g;
        unique case (idx)
            4'd0:    g = 15'd16512;
            4'd1:    g = 15'd8256;
            4'd2:    g = 15'd4128;
            4'd3:    g = 15'd2064;
            4'd4:    g = 15'd1032;
            4'd5:    g = 15'd516;
            4'd6:    g = 15'd258;
            4'd7:    g = 15'd192;
            4'd8:    g = 15'd129;
            4'd9:    g = 15'd88;
            4'd10:   g = 15'd64;
            4'd11:   g = 15'd56;
            4'd12:   g = 15'd48;
            4'd13:   g = 15'd40;
            4'd14:   g = 15'd36;
            default: g = 15'd32;
        endcase
        return g;
    endfunction

endpackage

@@ sv/bsspd_scale.sv @@
// Sample scaler: gain multiply, arithmetic shift right and 16-bit saturation.
module bsspd_scale (
    input  logic signed [7:0]  i_sample,
    input  bsspd_pkg::t_gain   i_gain,
    output logic signed [15:0] o_scaled
);
    import bsspd_pkg::*;

    logic signed [GAIN_W:0]     gain_s;
    logic signed [PROD_W-1:0]   prod;
    logic signed [SCALED_W-1:0] shifted;

    assign gain_s  = signed'({1'b0, i_gain});
    assign prod    = PROD_W'(gain_s) * PROD_W'(i_sample);
    // floor division by 32
    assign shifted = prod[PROD_W-1:SHIFT];

    always_comb begin
        if (shifted[SCALED_W-1:15] == '0 || shifted[SCALED_W-1:15] == '1) begin
            o_scaled = shifted[15:0];
        end else if (shifted[SCALED_W-1]) begin
            o_scaled = SAMPLE_MIN;
        end else begin
            o_scaled = SAMPLE_MAX;
        end
    end

endmodule

@@ sv/block_scaled_stereo_pcm_decoder.sv @@
// Top level of the block-scaled stereo PCM decoder: packet parser, gain stage and output register.
//
// Takes one packet byte per cycle, back to back, while o_stall is low, and gives at most one item per byte.
// The parser and gain lookup run in the accept cycle and are held in a register; the
// multiply and clip run from that register into the output register. Count, code and
// trailing bytes make no item unless they close the packet. An item waits in the
// output register while o_valid is high and i_stall holds it; the input side stalls
// only when both registers are full.
module block_scaled_stereo_pcm_decoder #(
    parameter int unsigned PAIRS_PER_BLOCK = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  bsspd_pkg::t_in_item   i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output bsspd_pkg::t_out_item  o_data
);
    import bsspd_pkg::*;

    localparam int unsigned LAST_POS_I = 2 * PAIRS_PER_BLOCK;
    localparam int unsigned POS_W      = $clog2(LAST_POS_I + 1);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(LAST_POS_I);

    // parser state
    logic [7:0]       r_blocks_left, n_blocks_left;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_code, n_code;
    logic             r_in_packet, n_in_packet;

    // gain stage
    logic              r_a_valid;
    logic signed [7:0] r_a_sample;
    t_gain             r_a_gain;
    logic              r_a_chan;
    logic              r_a_sval;
    logic              r_a_last;
    logic              r_a_short;

    // output register
    logic      r_o_valid;
    t_out_item r_o_data;

    logic             accept;
    logic             emit;
    logic             is_sample;
    logic             chan;
    t_gain            gain;
    logic             b_load;
    logic signed [15:0] scaled;
    logic [7:0]       rot;

    assign b_load  = r_a_valid && (!r_o_valid || !i_stall);
    assign o_stall = r_a_valid && r_o_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    assign rot  = {i_data.data_byte[0], i_data.data_byte[7:1]};
    assign chan = ~r_pos[0];
    assign gain = gain_lookup(chan ? r_code[7:4] : r_code[3:0]);

    always_comb begin
        n_blocks_left = r_blocks_left;
        n_pos         = r_pos;
        n_code        = r_code;
        n_in_packet   = r_in_packet;
        is_sample     = 1'b0;
        emit          = 1'b0;
        if (i_data.packet_start) begin
            n_blocks_left = i_data.data_byte;
            n_pos         = '0;
            n_in_packet   = 1'b1;
        end else if (r_in_packet && r_blocks_left != '0) begin
            if (r_pos == '0) begin
                n_code = rot;
                n_pos  = POS_W'(1);
            end else begin
                is_sample = 1'b1;
                if (r_pos == LAST_POS) begin
                    n_pos         = '0;
                    n_blocks_left = r_blocks_left - 8'd1;
                end else begin
                    n_pos = r_pos + POS_W'(1);
                end
            end
        end
        if (i_data.packet_start || r_in_packet) begin
            emit = is_sample || i_data.packet_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blocks_left <= '0;
            r_pos         <= '0;
            r_code        <= '0;
            r_in_packet   <= 1'b0;
        end else if (accept) begin
            r_code <= n_code;
            if (emit && i_data.packet_end) begin
                // close the packet
                r_blocks_left <= '0;
                r_pos         <= '0;
                r_in_packet   <= 1'b0;
            end else begin
                r_blocks_left <= n_blocks_left;
                r_pos         <= n_pos;
                r_in_packet   <= n_in_packet;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (accept && emit) begin
            r_a_valid <= 1'b1;
        end else if (b_load) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_a_sample <= signed'(i_data.data_byte);
            r_a_gain   <= gain;
            r_a_chan   <= is_sample ? chan : CHAN_LEFT;
            r_a_sval   <= is_sample;
            r_a_last   <= i_data.packet_end;
            r_a_short  <= i_data.packet_end && (n_blocks_left != '0 || n_pos != '0);
        end
    end

    bsspd_scale u_scale (
        .i_sample (r_a_sample),
        .i_gain   (r_a_gain),
        .o_scaled (scaled)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (b_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_load) begin
            r_o_data.sample         <= r_a_sval ? scaled : 16'sd0;
            r_o_data.channel        <= r_a_chan;
            r_o_data.sample_valid   <= r_a_sval;
            r_o_data.last_of_packet <= r_a_last;
            r_o_data.short_packet   <= r_a_short;
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

endmodule
